FILE: src/bcs_pkg.sv
// Shared types and constants for the Bezier curve sampler.
// Depends on nothing; every module of the sampler imports it.
`timescale 1ns / 1ps
`default_nettype none

package bcs_pkg;

   localparam int BCS_MAX_POINTS   = 16;
   localparam int BCS_MAX_SEGMENTS = 64;

   // Fixed field widths of the words on the ports
   localparam int COORD_W    = 32;
   localparam int SEG_W      = 7;
   localparam int T_W        = 16;
   localparam int STEP_W     = 17;
   localparam int STEP_IDX_W = 6;
   localparam int STEP_DEPTH = 64;

   localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(16);

   // floor(65536 / n) for n = 1 .. 64, entry n-1
   localparam logic [STEP_W-1:0] STEP_TABLE [STEP_DEPTH] = '{
      17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
      17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,
      17'd4369,  17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,
      17'd2978,  17'd2849,  17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,
      17'd2259,  17'd2184,  17'd2114,  17'd2048,  17'd1985,  17'd1927,  17'd1872,
      17'd1820,  17'd1771,  17'd1724,  17'd1680,  17'd1638,  17'd1598,  17'd1560,
      17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,  17'd1365,  17'd1337,
      17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191,  17'd1170,
      17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,  17'd1040,
      17'd1024
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIFF,
      ST_MUL,
      ST_ADD,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept_point;
      logic start_burst;
      logic load;
      logic diff;
      logic mul;
      logic add;
      logic shift;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic one_point;
      logic pair_last;
      logic level_last;
      logic sample_last;
   } status_type;

endpackage

`default_nettype wire

FILE: src/bcs_ctrl.sv
// Sequencer of the Bezier curve sampler: point loading and evaluation steps.
// Depends on bcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcs_ctrl
   import bcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_last_point,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_last_point) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = status.one_point ? ST_EMIT : ST_DIFF;
         end
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD: begin
            state_in = status.pair_last ? ST_SHIFT : ST_DIFF;
         end
         ST_SHIFT: begin
            state_in = status.level_last ? ST_EMIT : ST_DIFF;
         end
         ST_EMIT: begin
            state_in = status.sample_last ? ST_IDLE : ST_LOAD;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy             = 1'b0;
            cmd.accept_point = start;
            cmd.start_burst  = start && req_last_point;
         end
         ST_LOAD:  cmd.load  = 1'b1;
         ST_DIFF:  cmd.diff  = 1'b1;
         ST_MUL:   cmd.mul   = 1'b1;
         ST_ADD:   cmd.add   = 1'b1;
         ST_SHIFT: cmd.shift = 1'b1;
         ST_EMIT:  cmd.emit  = 1'b1;
         default:  cmd       = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(state_ff) == ST_MUL)
      else $error("add step not preceded by multiply step");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> $past(state_ff) == ST_IDLE || $past(state_ff) == ST_EMIT)
      else $error("work load outside burst start or sample boundary");

endmodule

`default_nettype wire

FILE: src/bcs_datapath.sv
// Datapath of the Bezier curve sampler: point store, work chain, interpolator.
// Depends on bcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcs_datapath
   import bcs_pkg::*;
#(
   parameter int MAX_POINTS   = BCS_MAX_POINTS,
   parameter int MAX_SEGMENTS = BCS_MAX_SEGMENTS
)(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [COORD_W-1:0] req_ctrl_x,
   input  logic signed [COORD_W-1:0] req_ctrl_y,
   input  logic                      csr_write_en,
   input  logic        [SEG_W-1:0]   csr_segments,
   output logic                      rsp_strobe,
   output logic signed [COORD_W-1:0] rsp_sample_x,
   output logic signed [COORD_W-1:0] rsp_sample_y,
   output logic                      rsp_last_sample,
   output logic                      rsp_points_dropped
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = DIFF_W + T_W + 1;

   // control state
   logic [CNT_W-1:0] point_count_ff, point_count_in;
   logic             overflow_ff, overflow_in;
   logic [SEG_W-1:0] segments_ff, segments_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   // payload
   logic signed [COORD_W-1:0] ctrl_x_ff [MAX_POINTS];
   logic signed [COORD_W-1:0] ctrl_x_in [MAX_POINTS];
   logic signed [COORD_W-1:0] ctrl_y_ff [MAX_POINTS];
   logic signed [COORD_W-1:0] ctrl_y_in [MAX_POINTS];
   logic signed [COORD_W-1:0] work_x_ff [MAX_POINTS];
   logic signed [COORD_W-1:0] work_x_in [MAX_POINTS];
   logic signed [COORD_W-1:0] work_y_ff [MAX_POINTS];
   logic signed [COORD_W-1:0] work_y_in [MAX_POINTS];
   logic [CNT_W-1:0]          level_ff, level_in;
   logic [CNT_W-1:0]          pair_ff, pair_in;
   logic signed [DIFF_W-1:0]  diff_x_ff, diff_x_in, diff_y_ff, diff_y_in;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [T_W-1:0]            t_ff, t_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [SEG_W-1:0]          nseg_ff, nseg_in;
   logic [SEG_W-1:0]          sample_cnt_ff, sample_cnt_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_drop_ff, rsp_drop_in;

   logic [SEG_W-1:0]          seg_sat;
   logic [SEG_W-1:0]          seg_dec;
   logic signed [COORD_W-1:0] lerp_x, lerp_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         overflow_ff    <= 1'b0;
         segments_ff    <= SEG_RESET;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         point_count_ff <= point_count_in;
         overflow_ff    <= overflow_in;
         segments_ff    <= segments_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_x_ff     <= ctrl_x_in;
      ctrl_y_ff     <= ctrl_y_in;
      work_x_ff     <= work_x_in;
      work_y_ff     <= work_y_in;
      level_ff      <= level_in;
      pair_ff       <= pair_in;
      diff_x_ff     <= diff_x_in;
      diff_y_ff     <= diff_y_in;
      prod_x_ff     <= prod_x_in;
      prod_y_ff     <= prod_y_in;
      t_ff          <= t_in;
      step_ff       <= step_in;
      nseg_ff       <= nseg_in;
      sample_cnt_ff <= sample_cnt_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   // Saturate the sample count into 1 .. MAX_SEGMENTS
   always_comb begin
      if (segments_ff == '0) begin
         seg_sat = SEG_W'(1);
      end else if (segments_ff > SEG_W'(MAX_SEGMENTS)) begin
         seg_sat = SEG_W'(MAX_SEGMENTS);
      end else begin
         seg_sat = segments_ff;
      end
      seg_dec = seg_sat - 1'b1;
   end

   // floor shift of the product is an arithmetic right shift; the sum wraps
   // exactly because the true result lies between the two operands
   assign lerp_x = work_x_ff[0] + prod_x_ff[T_W +: COORD_W];
   assign lerp_y = work_y_ff[0] + prod_y_ff[T_W +: COORD_W];

   // point store and configuration
   always_comb begin
      segments_in    = csr_write_en ? csr_segments : segments_ff;
      point_count_in = point_count_ff;
      overflow_in    = overflow_ff;
      ctrl_x_in      = ctrl_x_ff;
      ctrl_y_in      = ctrl_y_ff;
      if (cmd.accept_point) begin
         if (point_count_ff < CNT_W'(MAX_POINTS)) begin
            for (int k = 0; k < MAX_POINTS; k++) begin
               if (CNT_W'(k) == point_count_ff) begin
                  ctrl_x_in[k] = req_ctrl_x;
                  ctrl_y_in[k] = req_ctrl_y;
               end
            end
            point_count_in = point_count_ff + 1'b1;
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.emit && status.sample_last) begin
         point_count_in = '0;
         overflow_in    = 1'b0;
      end
   end

   // work chain and interpolator
   always_comb begin
      work_x_in = work_x_ff;
      work_y_in = work_y_ff;
      level_in  = level_ff;
      pair_in   = pair_ff;
      diff_x_in = diff_x_ff;
      diff_y_in = diff_y_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      if (cmd.load) begin
         work_x_in = ctrl_x_ff;
         work_y_in = ctrl_y_ff;
         level_in  = point_count_ff;
         pair_in   = '0;
      end
      if (cmd.diff) begin
         diff_x_in = DIFF_W'(work_x_ff[1]) - DIFF_W'(work_x_ff[0]);
         diff_y_in = DIFF_W'(work_y_ff[1]) - DIFF_W'(work_y_ff[0]);
      end
      if (cmd.mul) begin
         // widen both operands first so the full product is kept
         prod_x_in = PROD_W'(diff_x_ff) * PROD_W'($signed({1'b0, t_ff}));
         prod_y_in = PROD_W'(diff_y_ff) * PROD_W'($signed({1'b0, t_ff}));
      end
      if (cmd.add) begin
         // advance the chain by one and drop the new point at the level's tail
         for (int k = 0; k < MAX_POINTS; k++) begin
            if (CNT_W'(k + 1) == level_ff) begin
               work_x_in[k] = lerp_x;
               work_y_in[k] = lerp_y;
            end else if (k < MAX_POINTS - 1) begin
               work_x_in[k] = work_x_ff[k + 1];
               work_y_in[k] = work_y_ff[k + 1];
            end
         end
         pair_in = pair_ff + 1'b1;
      end
      if (cmd.shift) begin
         for (int k = 0; k < MAX_POINTS - 1; k++) begin
            work_x_in[k] = work_x_ff[k + 1];
            work_y_in[k] = work_y_ff[k + 1];
         end
         level_in = level_ff - 1'b1;
         pair_in  = '0;
      end
   end

   // burst sequencing and result word
   always_comb begin
      t_in          = t_ff;
      step_in       = step_ff;
      nseg_in       = nseg_ff;
      sample_cnt_in = sample_cnt_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_strobe_in = cmd.emit;
      if (cmd.start_burst) begin
         t_in          = '0;
         step_in       = STEP_TABLE[seg_dec[STEP_IDX_W-1:0]];
         nseg_in       = seg_sat;
         sample_cnt_in = '0;
      end
      if (cmd.emit) begin
         rsp_x_in      = work_x_ff[0];
         rsp_y_in      = work_y_ff[0];
         rsp_last_in   = status.sample_last;
         rsp_drop_in   = overflow_ff;
         t_in          = t_ff + step_ff[T_W-1:0];
         sample_cnt_in = sample_cnt_ff + 1'b1;
      end
   end

   assign status.one_point   = (point_count_ff == CNT_W'(1));
   assign status.pair_last   = ((pair_ff + CNT_W'(2)) == level_ff);
   assign status.level_last  = (level_ff == CNT_W'(2));
   assign status.sample_last = (sample_cnt_ff == (nseg_ff - 1'b1));

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_sample_x       = rsp_x_ff;
   assign rsp_sample_y       = rsp_y_ff;
   assign rsp_last_sample    = rsp_last_ff;
   assign rsp_points_dropped = rsp_drop_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |-> point_count_ff == '0 && !overflow_ff)
      else $error("point store not cleared after final sample");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> level_ff != '0 && level_ff <= CNT_W'(MAX_POINTS))
      else $error("work chain loaded with bad point count");

   assert property (@(posedge clock) disable iff (reset)
      cmd.add |-> (pair_ff + CNT_W'(2)) <= level_ff)
      else $error("interpolation pair index past end of level");

   assert property (@(posedge clock) disable iff (reset)
      point_count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

endmodule

`default_nettype wire

FILE: src/bezier_curve_sampler_unit.sv
// Top level of the Bezier curve sampler: sequencer plus datapath.
// Depends on bcs_pkg, bcs_ctrl and bcs_datapath.
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ---------------------------------
//  request   req_ctrl_x, req_ctrl_y,             word taken when start && !busy
//            req_last_point
//  response  rsp_sample_x, rsp_sample_y,         word valid for one cycle with
//            rsp_last_sample, rsp_points_dropped rsp_strobe; no back-pressure
//  config    csr_segments                        written when csr_write_en
//
// Control points load one word per cycle while busy is low. The word with
// req_last_point set starts a burst of segments samples (clamped to
// 1..MAX_SEGMENTS); busy stays high through the emit step of the final sample
// and drops in the cycle that strobes it.
// For each sample with n stored points, the single shared interpolator spends
// a subtract, a multiply and an add step on each point pair, plus one chain
// shift per level, one load and one emit.
// Reset (synchronous, active high) empties the point store, clears the
// overflow flag and sets segments to 16. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_sampler_unit
   import bcs_pkg::*;
#(
   parameter int MAX_POINTS   = BCS_MAX_POINTS,
   parameter int MAX_SEGMENTS = BCS_MAX_SEGMENTS
)(
   input  logic                      clock,
   input  logic                      reset,
   // request words
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_ctrl_x,
   input  logic signed [COORD_W-1:0] req_ctrl_y,
   input  logic                      req_last_point,
   // response words
   output logic                      rsp_strobe,
   output logic signed [COORD_W-1:0] rsp_sample_x,
   output logic signed [COORD_W-1:0] rsp_sample_y,
   output logic                      rsp_last_sample,
   output logic                      rsp_points_dropped,
   // configuration
   input  logic                      csr_write_en,
   input  logic        [SEG_W-1:0]   csr_segments
);

   cmd_type    cmd;
   status_type status;

   // sequencer: walks each sample through load, pair steps, level shifts, emit
   bcs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last_point (req_last_point),
      .status         (status),
      .busy           (busy),
      .cmd            (cmd)
   );

   // datapath: point store, work chain, interpolator and result register
   bcs_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_ctrl_x         (req_ctrl_x),
      .req_ctrl_y         (req_ctrl_y),
      .csr_write_en       (csr_write_en),
      .csr_segments       (csr_segments),
      .rsp_strobe         (rsp_strobe),
      .rsp_sample_x       (rsp_sample_x),
      .rsp_sample_y       (rsp_sample_y),
      .rsp_last_sample    (rsp_last_sample),
      .rsp_points_dropped (rsp_points_dropped)
   );

endmodule

`default_nettype wire
